FILE: rtl/core/multi_threshold_pulse_scaler_core_assert.svh
// Assertion macros used by the checker file of the pulse scaler core.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MULTI_THRESHOLD_PULSE_SCALER_CORE_ASSERT_SVH
`define MULTI_THRESHOLD_PULSE_SCALER_CORE_ASSERT_SVH

// Plain property, sampled on the rising clock edge, off while in reset.
`define MTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from an antecedent to a consequent.
`define MTPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mtps_pkg.sv
// Package of the multi-threshold pulse scaler core: widths, codes and
// request and response types. Depends on nothing.
`default_nettype none

package mtps_pkg;

  localparam int NUM_LEVELS_DEF = 128;
  localparam int SAMPLE_W       = 14;
  localparam int HOLD_W         = 16;
  localparam int COUNT_W        = 32;
  localparam int LEVEL_W        = 7;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [SAMPLE_W-1:0] TOP_RESET  = 14'd3662;
  localparam logic [HOLD_W-1:0]   HOLD_RESET = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF       = 1'd1;

  typedef enum logic [1:0] {
    MODE_FEED  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]  level_index;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_index_out;
    logic [COUNT_W-1:0] pulse_count;
  } rsp_t;

  // Per-cycle commands broadcast to every level.
  typedef struct packed {
    logic feed;
    logic clear;
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/mtps_lane.sv
// One threshold level: armed flag, hold-off counter and saturating pulse count.
// Depends on mtps_pkg.
`default_nettype none

module mtps_lane #(
  parameter int LEVEL = 0,
  parameter int SUM_W = 15
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire mtps_pkg::lane_ctl_t      ctl_i,
  input  wire [mtps_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire [mtps_pkg::SAMPLE_W-1:0]  top_i,
  input  wire [mtps_pkg::HOLD_W-1:0]    holdoff_i,
  output logic [mtps_pkg::COUNT_W-1:0]  count_o
);
  import mtps_pkg::*;

  logic               armed_q, armed_d;
  logic [HOLD_W-1:0]  since_q, since_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0]   smp_sum, top_ext;
  logic               below, above;
  logic [HOLD_W-1:0]  since_inc;

  // sample < top - LEVEL is the same as sample + LEVEL < top, with no sign.
  assign smp_sum   = SUM_W'(sample_i) + SUM_W'(LEVEL);
  assign top_ext   = SUM_W'(top_i);
  assign below     = smp_sum < top_ext;
  assign above     = smp_sum > top_ext;
  assign since_inc = (since_q == '1) ? since_q : since_q + HOLD_W'(1);

  always_comb begin
    armed_d = armed_q;
    since_d = since_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.feed) begin
      if (armed_q && below) begin
        if (count_q != '1) begin
          count_d = count_q + COUNT_W'(1);
        end
        armed_d = 1'b0;
        since_d = '0;
      end else if (!armed_q) begin
        since_d = since_inc;
        if (above && (since_inc > holdoff_i)) begin
          armed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      since_q <= '0;
      count_q <= '0;
    end else begin
      armed_q <= armed_d;
      since_q <= since_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/multi_threshold_pulse_scaler_core.sv
// Top level of the multi-threshold pulse scaler: request register, bank of
// threshold levels and response register. Depends on mtps_pkg and mtps_lane.
//
//   Channel   Handshake                Payload        Direction
//   request   in_valid_i / in_ready_o  in_req_i       in
//   response  out_valid_o / out_ready_i out_rsp_o     out
//   config    cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i  in
//
// One request is taken in every clock cycle while no read request is held up.
// A request waits in the request register, where all levels compare and update
// in parallel; a read request then loads the response register, which presents
// its response. Feed and clear requests give no response and
// move on even while a response is stalled; a read request waits in the
// request register only while the response register is full and not taken.
// Reset arms every level and clears all hold-off counters and pulse counts at
// once, and loads the register defaults.
`default_nettype none

module multi_threshold_pulse_scaler_core #(
  parameter int NUM_LEVELS = mtps_pkg::NUM_LEVELS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire mtps_pkg::req_t             in_req_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output mtps_pkg::rsp_t                  out_rsp_o,
  input  wire                             cfg_we_i,
  input  wire [mtps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [mtps_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import mtps_pkg::*;

  // Width of a level number, and width of the sample-plus-level sum.
  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SUM_W = ((SAMPLE_W > LW) ? SAMPLE_W : LW) + 1;

  // Configuration registers.
  logic [SAMPLE_W-1:0] top_q;
  logic [HOLD_W-1:0]   holdoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= TOP_RESET;
      holdoff_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD_TOP: top_q     <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_HOLDOFF:       holdoff_q <= cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Request register.
  logic      in_valid_q;
  req_t      in_q;
  logic      out_valid_q;
  logic      is_read, out_free, advance;
  lane_ctl_t ctl;

  assign is_read    = in_valid_q && (in_q.mode == MODE_READ);
  assign out_free   = !out_valid_q || out_ready_i;
  // Only a read needs room in the response register.
  assign advance    = in_valid_q && (!is_read || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_comb begin
    ctl = '0;
    case (in_q.mode)
      MODE_FEED:  ctl.feed  = advance;
      MODE_CLEAR: ctl.clear = advance;
      default:    ctl       = '0;
    endcase
  end

  // Bank of levels, each with a fixed threshold offset.
  logic [COUNT_W-1:0] counts [NUM_LEVELS];

  for (genvar j = 0; j < NUM_LEVELS; j++) begin : g_lane
    mtps_lane #(
      .LEVEL (j),
      .SUM_W (SUM_W)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .sample_i  (in_q.sample),
      .top_i     (top_q),
      .holdoff_i (holdoff_q),
      .count_o   (counts[j])
    );
  end

  // Read selection; a level beyond the bank reads as zero.
  logic [LW-1:0]      rd_idx;
  logic               rd_hit;
  logic [COUNT_W-1:0] rd_count;

  assign rd_idx   = LW'(in_q.level_index);
  assign rd_hit   = 32'(in_q.level_index) < 32'(NUM_LEVELS);
  assign rd_count = rd_hit ? counts[rd_idx] : '0;

  // Response register.
  rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_read) begin
      out_q.level_index_out <= in_q.level_index;
      out_q.pulse_count     <= rd_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/mtps_checker.sv
// Port-level checker of the pulse scaler core, bound to the top level.
// Depends on mtps_pkg and multi_threshold_pulse_scaler_core_assert.svh.
`default_nettype none

`include "multi_threshold_pulse_scaler_core_assert.svh"

module mtps_checker #(
  parameter int NUM_LEVELS = mtps_pkg::NUM_LEVELS_DEF
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire mtps_pkg::req_t in_req_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire mtps_pkg::rsp_t out_rsp_o
);
  import mtps_pkg::*;

  // A stalled response keeps its contents.
  `MTPS_ASSERT(a_rsp_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)), "response changed while stalled")

  // A fresh response comes from a read request accepted at the input.
  `MTPS_ASSERT_IMP(a_rsp_from_read, $rose(out_valid_o), $past(in_valid_i && in_ready_o && (in_req_i.mode == MODE_READ), 2), "response without a read request")

  // It carries the level number of that request.
  `MTPS_ASSERT_IMP(a_rsp_level, $rose(out_valid_o), out_rsp_o.level_index_out == $past(in_req_i.level_index, 2), "response level does not match request")

  // A level beyond the bank always reads as zero.
  `MTPS_ASSERT_IMP(a_rsp_range, out_valid_o && (32'(out_rsp_o.level_index_out) >= 32'(NUM_LEVELS)), out_rsp_o.pulse_count == '0, "nonzero count for level beyond the bank")

endmodule

bind multi_threshold_pulse_scaler_core mtps_checker #(
  .NUM_LEVELS (NUM_LEVELS)
) u_mtps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for multi_threshold_pulse_scaler_core: drives requests,
// predicts every level's pulse count in the bench, and checks each read response.
// Depends on mtps_pkg and the core RTL only.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtps_pkg::*;

  localparam int NUM_LEVELS = NUM_LEVELS_DEF;
  // The core passes a read response through its request and response registers;
  // the settle wait covers feed requests still in flight when the queue empties.
  localparam int SETTLE_CYCLES = 6;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam logic [HOLD_W-1:0] HOLD_SAT = {HOLD_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
  // The fourth mode encoding has no meaning and must leave the core untouched.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  multi_threshold_pulse_scaler_core #(
    .NUM_LEVELS(NUM_LEVELS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Bench copy of the discriminator bank. Every level keeps its own armed flag,
  // its hold-off counter and its saturating pulse count.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] top_thr;
  logic [HOLD_W-1:0] holdoff;
  bit level_armed[NUM_LEVELS];
  int unsigned level_since[NUM_LEVELS];
  logic [COUNT_W-1:0] level_count[NUM_LEVELS];

  // Read responses that the core still owes, oldest first.
  rsp_t expected_reads[$];

  int mismatches = 0;
  bit idle_on = 1'b0;      // random gaps on both channels when set
  int hold_off_len = 0;    // a long receiver stall requested by a test

  function automatic void reset_levels();
    top_thr = TOP_RESET;
    holdoff = HOLD_RESET;
    for (int j = 0; j < NUM_LEVELS; j++) begin
      level_armed[j] = 1'b1;
      level_since[j] = 0;
      level_count[j] = '0;
    end
  endfunction

  // All levels see the sample at once. Level j compares against top_thr - j as
  // a signed value, so low settings of top_thr give negative thresholds that no
  // sample can fall below.
  function automatic void count_pulses(logic [SAMPLE_W-1:0] smp);
    int thr;
    int s;
    s = int'(smp);
    for (int j = 0; j < NUM_LEVELS; j++) begin
      thr = int'(top_thr) - j;
      if (level_armed[j] && s < thr) begin
        if (level_count[j] != COUNT_SAT) level_count[j] = level_count[j] + 1'b1;
        level_armed[j] = 1'b0;
        level_since[j] = 0;
      end else if (!level_armed[j]) begin
        // The hold-off counter saturates, so a hold-off at its maximum never
        // lets the level re-arm.
        if (level_since[j] < HOLD_SAT) level_since[j]++;
        if (s > thr && level_since[j] > holdoff) level_armed[j] = 1'b1;
      end
    end
  endfunction

  // Applies one accepted request to the bench state and queues the response
  // that a read request must produce.
  function automatic void predict_request(req_t r);
    rsp_t rsp;
    case (r.mode)
      MODE_FEED: begin
        count_pulses(r.sample);
      end
      MODE_READ: begin
        rsp.level_index_out = r.level_index;
        rsp.pulse_count = (int'(r.level_index) < NUM_LEVELS) ?
                          level_count[r.level_index] : '0;
        expected_reads = {expected_reads, rsp};
      end
      MODE_CLEAR: begin
        // Clearing touches the counts only; armed flags and hold-off counters stay.
        for (int j = 0; j < NUM_LEVELS; j++) level_count[j] = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(logic [1:0] mode, logic [SAMPLE_W-1:0] smp,
                                    logic [LEVEL_W-1:0] lvl);
    req_t r;
    r.mode = mode;
    r.sample = smp;
    r.level_index = lvl;
    return r;
  endfunction

  // A sample at the given distance from the level-zero threshold, clipped to
  // the ADC range.
  function automatic logic [SAMPLE_W-1:0] near_threshold(int offset);
    int v;
    v = int'(top_thr) + offset;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Valid goes high after an optional gap and holds with a steady
  // payload until the core takes the request; back-to-back requests keep valid
  // high so it is never dropped and raised within one time step.
  // ---------------------------------------------------------------------------
  task automatic send_req(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(r);
  endtask

  task automatic feed(logic [SAMPLE_W-1:0] smp);
    send_req(make_req(MODE_FEED, smp, LEVEL_W'($urandom)));
  endtask

  task automatic read_level(logic [LEVEL_W-1:0] lvl);
    send_req(make_req(MODE_READ, SAMPLE_W'($urandom), lvl));
  endtask

  task automatic clear_counts();
    send_req(make_req(MODE_CLEAR, SAMPLE_W'($urandom), LEVEL_W'($urandom)));
  endtask

  task automatic send_unused();
    send_req(make_req(MODE_UNUSED, SAMPLE_W'($urandom), LEVEL_W'($urandom)));
  endtask

  // Stops offering requests and waits until every read has been answered and
  // any trailing feed or clear request has left the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // Bits above the register width are dropped by the core.
    if (idx == REG_THRESHOLD_TOP) top_thr = value[SAMPLE_W-1:0];
    else if (idx == REG_HOLDOFF) holdoff = value[HOLD_W-1:0];
  endtask

  // Register writes happen only with the core idle. The spare upper bits of the
  // threshold write are random to show that they are ignored.
  task automatic set_config(logic [SAMPLE_W-1:0] top, logic [HOLD_W-1:0] hold);
    drain();
    write_reg(REG_THRESHOLD_TOP, {2'($urandom), top});
    write_reg(REG_HOLDOFF, hold);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready idles at random, and a test can ask for one long
  // stall that this process counts out on its own.
  // ---------------------------------------------------------------------------
  initial begin : response_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        stall_left = hold_off_len;
        hold_off_len = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Every response taken by the bench is matched against the oldest pending read.
  rsp_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("response with no read pending: level %0d count %0d",
                                  out_rsp.level_index_out, out_rsp.pulse_count));
      end else begin
        want = expected_reads.pop_front();
        if (out_rsp.level_index_out !== want.level_index_out)
          report_mismatch($sformatf("level_index_out expected %0d got %0d",
                                    want.level_index_out, out_rsp.level_index_out));
        if (out_rsp.pulse_count !== want.pulse_count)
          report_mismatch($sformatf("pulse_count of level %0d expected %0d got %0d",
                                    want.level_index_out, want.pulse_count,
                                    out_rsp.pulse_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset every count reads zero, at both ends of the bank.
  task automatic test_reset_state();
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(NUM_LEVELS - 1));
  endtask

  // Walks a few samples around the reset threshold: a sample equal to a
  // threshold neither triggers nor re-arms, a sample one below triggers, a
  // sample at zero triggers all armed levels, full scale re-arms them, and the
  // deepest level sits exactly at its threshold. The unused mode changes
  // nothing and a clear zeroes the counts.
  task automatic test_feed_edges();
    feed(TOP_RESET);
    feed(TOP_RESET - 1'b1);
    feed('0);
    feed(SAMPLE_W'(SAMPLE_MAX));
    feed(TOP_RESET - SAMPLE_W'(NUM_LEVELS - 1));
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(1));
    read_level(LEVEL_W'(64));
    read_level(LEVEL_W'(NUM_LEVELS - 1));
    send_unused();
    read_level(LEVEL_W'(0));
    clear_counts();
    read_level(LEVEL_W'(0));
  endtask

  // Threshold at zero leaves every level but the first with a negative
  // threshold; threshold at full scale leaves level zero unable to re-arm.
  task automatic test_threshold_extremes();
    set_config('0, '0);
    feed('0);
    feed(SAMPLE_W'(SAMPLE_MAX));
    feed('0);
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(5));
    set_config(SAMPLE_W'(SAMPLE_MAX), '0);
    feed(SAMPLE_W'(SAMPLE_MAX));
    feed(SAMPLE_W'(SAMPLE_MAX - 1));
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(NUM_LEVELS - 1));
  endtask

  // With the hold-off at its maximum a triggered level stays disarmed through
  // a quiet stretch, so a second dip adds nothing. Once the hold-off is lowered
  // below the count already reached, the next quiet sample re-arms the level.
  task automatic test_holdoff_limit();
    idle_on = 1'b0;
    set_config(SAMPLE_W'(8000), HOLD_SAT);
    feed(SAMPLE_W'(100));
    repeat (64) feed(SAMPLE_W'(SAMPLE_MAX));
    feed(SAMPLE_W'(100));
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(NUM_LEVELS - 1));
    set_config(SAMPLE_W'(8000), HOLD_W'(16));
    feed(SAMPLE_W'(SAMPLE_MAX));
    feed(SAMPLE_W'(100));
    read_level(LEVEL_W'(0));
    read_level(LEVEL_W'(NUM_LEVELS - 1));
  endtask

  // The receiver stops for a long stretch while the sender keeps offering a
  // dense mix of reads and feeds, so the response register fills and read
  // requests back up into the request register and stall the input.
  task automatic test_backpressure();
    set_config(TOP_RESET, HOLD_RESET);
    idle_on = 1'b0;
    hold_off_len = 300;
    repeat (80) begin
      if ($urandom_range(0, 1) == 0) read_level(LEVEL_W'($urandom));
      else feed(near_threshold($urandom_range(0, 160) - 140));
    end
    drain();
  endtask

  // One random phase at a given setting. Most traffic is pulse-shaped: a short
  // baseline above the bank, then a dip of random depth into it, so levels
  // trigger, wait out their hold-off and re-arm. The rest is reads, samples at
  // and around the threshold, full-range noise, clears and unused requests.
  task automatic run_phase(logic [SAMPLE_W-1:0] top, logic [HOLD_W-1:0] hold,
                           bit gaps, int n_items);
    int sent;
    int pick;
    set_config(top, hold);
    idle_on = gaps;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(0, 6)) begin
          feed(near_threshold($urandom_range(1, 40)));
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          feed(near_threshold(-$urandom_range(0, NUM_LEVELS + 8)));
          sent++;
        end
      end else if (pick < 80) begin
        read_level(LEVEL_W'($urandom));
        sent++;
      end else if (pick < 88) begin
        feed(SAMPLE_W'($urandom));
        sent++;
      end else if (pick < 94) begin
        feed(near_threshold($urandom_range(0, 6) - 3));
        sent++;
      end else if (pick < 97) begin
        clear_counts();
        sent++;
      end else begin
        send_unused();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(TOP_RESET, HOLD_RESET, 1'b1, 210);
    run_phase('0, '0, 1'b1, 210);
    run_phase(SAMPLE_W'(NUM_LEVELS - 1), HOLD_W'(2), 1'b0, 210);
    run_phase(SAMPLE_W'(SAMPLE_MAX), HOLD_SAT, 1'b1, 210);
    run_phase(SAMPLE_W'($urandom), HOLD_W'($urandom_range(0, 20)), 1'b1, 210);
    run_phase(SAMPLE_W'($urandom), HOLD_W'($urandom), 1'b1, 210);
    run_phase(SAMPLE_W'(3530), HOLD_W'(1), 1'b1, 210);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: one reset, the directed tests, then the random phases.
  // ---------------------------------------------------------------------------
  initial begin
    reset_levels();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_feed_edges();
    test_threshold_extremes();
    test_holdoff_limit();
    test_backpressure();
    test_random_traffic();

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a fifth of this.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
